// ===== hdl/eprc_pkg.sv =====
package eprc_pkg;

  // Per-channel measurement phase as it is held in the state memory.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_RISING   = 2'd1,
    PH_MEASURED = 2'd2
  } phase_t;

  // Request codes carried in the input tuser. Every other code is a status read.
  localparam logic [1:0] REQ_TRIGGER = 2'd0;
  localparam logic [1:0] REQ_CAPTURE = 2'd1;

  // Division by 58 is (w >> 1) / 29, done as a multiply by ceil(2^36 / 29)
  // followed by a right shift of 36. The product stays exact for all 31-bit operands.
  localparam logic [31:0] DIV58_MAGIC = 32'd2369637129;
  localparam int          DIV58_SHIFT = 36;
  localparam int          PROD_W      = 63;
  localparam int          QUOT_W      = PROD_W - DIV58_SHIFT;

  localparam logic [15:0] INVALID_CM      = 16'hFFFF;
  localparam logic [15:0] MAX_RANGE_RESET = 16'd400;

  // Load enables of the two registered stages in the distance unit.
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } div_ctl_t;

endpackage

// ===== hdl/echo_pulse_ranging_channels.sv =====
// An accepted beat passes stage 1, stage 2, stage 3 and the output register.
// Throughput: one request beat per cycle while results are taken; the per-channel
// state memory does one read and one write-back per cycle, with neighbor forwarding.
// A stalled result holds the pipe only as far back as its empty stages allow.
// Reset (rst, synchronous, active high) empties the pipe, marks every channel idle
// with zero times, and sets max_range_cm to 400. There is no clearing pass.
module echo_pulse_ranging_channels import eprc_pkg::*; #(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // channel[1:0], capture_count[33:2], zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_channel[1:0], pulse_us[33:2],
                                      // distance_cm[49:34], zero pad
  output logic [2:0]  m_axis_tuser,   // chan_state[1:0], pulse_valid[2]
  // Range limit register.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // One memory word per channel: phase, rise time, echo width (lowest first).
  localparam int DW = 2 + 2 * COUNT_BITS;

  // The user must write the range limit only while the pipe is empty; the block does not enforce it.
  logic [15:0] max_range_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range_cm <= MAX_RANGE_RESET;
    end else if (cfg_wr_en) begin
      max_range_cm <= cfg_wr_data;
    end
  end

  // Request fields as they sit on the slave side.
  logic [1:0]            in_ch;
  logic [COUNT_BITS-1:0] in_cnt;
  logic                  in_ok;

  assign in_ch  = s_axis_tdata[1:0];
  assign in_cnt = s_axis_tdata[2 +: COUNT_BITS];
  assign in_ok  = ({30'd0, in_ch} < 32'(NUM_CHANNELS));

  // Stage occupancy. A stage can take a new beat when it is empty or when its
  // own beat moves on in the same cycle, so bubbles collapse under a stall.
  logic v1, v2, v3;
  logic s1_free, s2_free, s3_free, s4_free;
  logic accept;

  assign s4_free       = !m_axis_tvalid || m_axis_tready;
  assign s3_free       = !v3 || s4_free;
  assign s2_free       = !v2 || s3_free;
  assign s1_free       = !v1 || s2_free;
  assign s_axis_tready = s1_free;
  assign accept        = s_axis_tvalid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        v1 <= accept;
      end
      if (s2_free) begin
        v2 <= v1;
      end
      if (s3_free) begin
        v3 <= v2;
      end
      if (s4_free) begin
        m_axis_tvalid <= v3;
      end
    end
  end

  // Stage 1: the memory read issued at accept returns here, the entry is updated
  // and, for a channel in range, written back as the beat leaves the stage.
  logic [1:0]            s1_req;
  logic [1:0]            s1_ch;
  logic [COUNT_BITS-1:0] s1_cnt;
  logic                  s1_ok;
  logic                  s1_fwd;

  logic [DW-1:0] rd_data;
  logic          rd_valid;
  logic [DW-1:0] fwd_data;
  logic [DW-1:0] cur;
  logic [DW-1:0] new_entry;
  logic          wr_en;

  phase_t                cur_phase;
  logic [COUNT_BITS-1:0] cur_rise;
  logic [COUNT_BITS-1:0] cur_width;
  phase_t                new_phase;
  logic [COUNT_BITS-1:0] new_rise;
  logic [COUNT_BITS-1:0] new_width;

  assign wr_en = v1 && s2_free && s1_ok;

  eprc_state_ram #(
    .DEPTH (NUM_CHANNELS),
    .DW    (DW)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (AW'(s1_ch)),
    .wr_data  (new_entry),
    .rd_en    (accept),
    .rd_addr  (AW'(in_ch)),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  // The memory returns the old word when the previous beat writes the same
  // channel in the cycle of the read, so that word is taken from the forward
  // register instead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_data <= new_entry;
    end
    if (accept) begin
      s1_req <= s_axis_tuser;
      s1_ch  <= in_ch;
      s1_cnt <= in_cnt;
      s1_ok  <= in_ok;
      s1_fwd <= wr_en && (s1_ch == in_ch);
    end
  end

  always_comb begin
    if (s1_fwd) begin
      cur = fwd_data;
    end else if (rd_valid) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    cur_phase = phase_t'(cur[1:0]);
    cur_rise  = cur[2 +: COUNT_BITS];
    cur_width = cur[2 + COUNT_BITS +: COUNT_BITS];

    new_phase = cur_phase;
    new_rise  = cur_rise;
    new_width = cur_width;
    case (s1_req)
      REQ_TRIGGER: begin
        new_phase = PH_IDLE;
      end
      REQ_CAPTURE: begin
        // A capture on a measured channel waits for the next trigger.
        if (cur_phase == PH_IDLE) begin
          new_rise  = s1_cnt;
          new_phase = PH_RISING;
        end else if (cur_phase == PH_RISING) begin
          new_width = s1_cnt - cur_rise;
          new_phase = PH_MEASURED;
        end
      end
      default: begin
        // Status read and the unused code change nothing.
      end
    endcase
    new_entry = {new_width, new_rise, new_phase};
  end

  // Stage 2: the channel view after the update. A channel beyond the last one
  // reports idle with a zero width.
  logic [1:0]  s2_ch;
  phase_t      s2_state;
  logic [31:0] s2_width;

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_ch <= s1_ch;
      if (s1_ok) begin
        s2_state <= new_phase;
        s2_width <= 32'(new_width);
      end else begin
        s2_state <= PH_IDLE;
        s2_width <= '0;
      end
    end
  end

  // Stage 3 and the output register: the distance unit multiplies into stage 3
  // and applies the range limit into the output register.
  logic [1:0]  s3_ch;
  phase_t      s3_state;
  logic [31:0] s3_width;
  logic [1:0]  o_ch;
  phase_t      o_state;
  logic [31:0] o_width;
  logic [15:0] o_dist;
  div_ctl_t    div_ctl;

  assign div_ctl.load_mul = s3_free;
  assign div_ctl.load_out = s4_free;

  eprc_range_div u_div (
    .clk          (clk),
    .ctl          (div_ctl),
    .pulse_us     (s2_width),
    .measured     (s2_state == PH_MEASURED),
    .max_range_cm (max_range_cm),
    .distance_cm  (o_dist)
  );

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_ch    <= s2_ch;
      s3_state <= s2_state;
      s3_width <= s2_width;
    end
    if (s4_free) begin
      o_ch    <= s3_ch;
      o_state <= s3_state;
      o_width <= s3_width;
    end
  end

  assign m_axis_tdata = {6'd0, o_dist, o_width, o_ch};
  assign m_axis_tuser = {(o_state == PH_MEASURED), o_state};

endmodule

// ===== hdl/eprc_state_ram.sv =====
module eprc_state_ram import eprc_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int DW    = 66,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  output logic          rd_valid
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads with rd_valid low, as the reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= written[rd_addr];
      end
    end
  end

endmodule

// ===== hdl/eprc_range_div.sv =====
module eprc_range_div import eprc_pkg::*; (
  input  logic        clk,
  input  div_ctl_t    ctl,
  input  logic [31:0] pulse_us,
  input  logic        measured,
  input  logic [15:0] max_range_cm,
  output logic [15:0] distance_cm
);

  logic [PROD_W-1:0] prod;
  logic              meas_q;
  logic [QUOT_W-1:0] quot;

  assign quot = prod[PROD_W-1:DIV58_SHIFT];

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      prod   <= PROD_W'(pulse_us[31:1]) * PROD_W'(DIV58_MAGIC);
      meas_q <= measured;
    end
    if (ctl.load_out) begin
      if (meas_q && (quot <= QUOT_W'(max_range_cm))) begin
        distance_cm <= quot[15:0];
      end else begin
        distance_cm <= INVALID_CM;
      end
    end
  end

endmodule

// ===== hdl/eprc_checker.sv =====
module eprc_checker import eprc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A result beat that is not taken stays as it is.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  // Requests are refused only when the whole pipe is backed up by the result side.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request side stalled without a result stall");

  // The valid flag follows the reported phase.
  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser[2] == (m_axis_tuser[1:0] == PH_MEASURED))
    else $error("pulse_valid disagrees with chan_state");

  // Without a measurement the distance reads as invalid.
  a_invalid_distance: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[49:34] == INVALID_CM)
    else $error("distance reported without a measurement");

endmodule

bind echo_pulse_ranging_channels eprc_checker u_eprc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
